// ----- hdl/mlrq_pkg.sv -----
`timescale 1ns / 1ps
package mlrq_pkg;

   // Default sizing of the queue set.
   localparam int LEVELS_DEFAULT      = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   // Fixed field widths of the request and response payloads.
   localparam int ID_W     = 8;
   localparam int LEVEL_W  = 4;
   localparam int STATUS_W = 3;

   // Request action codes.
   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic pick;
      logic scan;
      logic enq_finish;
      logic deq_read;
      logic deq_finish;
      logic empty_finish;
      logic push;
   } mlrq_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_deq;
      logic any_ready;
      logic scan_done;
      logic out_free;
   } mlrq_stat_type;

endpackage

// ----- hdl/mlrq_req_if.sv -----
`timescale 1ns / 1ps
interface mlrq_req_if;
   import mlrq_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [ID_W-1:0]    task_id;
   logic [LEVEL_W-1:0] level;

   modport source (output valid, output action, output task_id, output level, input ready);
   modport sink   (input valid, input action, input task_id, input level, output ready);
endinterface

// ----- hdl/mlrq_rsp_if.sv -----
`timescale 1ns / 1ps
interface mlrq_rsp_if;
   import mlrq_pkg::*;

   logic                valid;
   logic                ready;
   logic [ID_W-1:0]     out_task_id;
   logic [LEVEL_W-1:0]  out_level;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output out_task_id, output out_level, output status,
                   input ready);
   modport sink   (input valid, input out_task_id, input out_level, input status,
                   output ready);
endinterface

// ----- hdl/multilevel_ready_queue_unit.sv -----
// An enqueue reads the ids held at its level from the store for the duplicate scan, one store
// read a cycle; an enqueue to an empty level and a dequeue need no scan.
// Only one request is in flight at a time, so a new request is taken only once the last one has
// finished; a finished response waits in an output register while the next request is worked on.
// Reset is synchronous and empties every level at once; the store needs no clearing pass.
`timescale 1ns / 1ps
module multilevel_ready_queue_unit #(
   parameter int LEVELS      = mlrq_pkg::LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mlrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   mlrq_req_if.sink   req,
   mlrq_rsp_if.source rsp
);
   import mlrq_pkg::*;

   mlrq_cmd_type  cmd;
   mlrq_stat_type stat;

   mlrq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlrq_datapath #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_action   (req.action),
      .in_task_id  (req.task_id),
      .in_level    (req.level),
      .out_ready   (rsp.ready),
      .out_valid   (rsp.valid),
      .out_task_id (rsp.out_task_id),
      .out_level   (rsp.out_level),
      .out_status  (rsp.status),
      .cmd         (cmd),
      .stat        (stat)
   );

   // An accepted request keeps the input closed until its response is produced.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while another was in flight");

   // Only a dequeue returns a task id.
   a_id_only_on_dequeue: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status != ST_DEQUEUED |-> rsp.out_task_id == '0)
      else $error("task id returned on a response that is not a dequeue");

   // An empty response carries level zero.
   a_empty_level_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status == ST_EMPTY |-> rsp.out_level == '0)
      else $error("empty response with a non-zero level");

   // A response never reports a level beyond the last one.
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> {1'b0, rsp.out_level} < (LEVEL_W + 1)'(LEVELS))
      else $error("response level out of range");
endmodule

// ----- hdl/mlrq_ram.sv -----
`timescale 1ns / 1ps
module mlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hdl/mlrq_ctrl.sv -----
`timescale 1ns / 1ps
module mlrq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  mlrq_pkg::mlrq_stat_type stat,
   output mlrq_pkg::mlrq_cmd_type  cmd
);
   import mlrq_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_LOAD     = 7'b0000010,
      S_SCAN     = 7'b0000100,
      S_ENQ_END  = 7'b0001000,
      S_DEQ_RD   = 7'b0010000,
      S_DEQ_WAIT = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Sequencing of one request through the datapath.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            if (!stat.is_deq) begin
               state_in = S_SCAN;
            end else if (stat.any_ready) begin
               cmd.pick = 1'b1;
               state_in = S_DEQ_RD;
            end else begin
               cmd.empty_finish = 1'b1;
               state_in         = S_DONE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_ENQ_END;
            end
         end
         S_ENQ_END: begin
            cmd.enq_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_DEQ_RD: begin
            cmd.deq_read = 1'b1;
            state_in     = S_DEQ_WAIT;
         end
         S_DEQ_WAIT: begin
            cmd.deq_finish = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hdl/mlrq_datapath.sv -----
`timescale 1ns / 1ps
module mlrq_datapath #(
   parameter int LEVELS      = mlrq_pkg::LEVELS_DEFAULT,
   parameter int QUEUE_DEPTH = mlrq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_action,
   input  logic [mlrq_pkg::ID_W-1:0]       in_task_id,
   input  logic [mlrq_pkg::LEVEL_W-1:0]    in_level,
   input  logic                            out_ready,
   output logic                            out_valid,
   output logic [mlrq_pkg::ID_W-1:0]       out_task_id,
   output logic [mlrq_pkg::LEVEL_W-1:0]    out_level,
   output logic [mlrq_pkg::STATUS_W-1:0]   out_status,
   input  mlrq_pkg::mlrq_cmd_type           cmd,
   output mlrq_pkg::mlrq_stat_type          stat
);
   import mlrq_pkg::*;

   localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRIES = LEVELS * QUEUE_DEPTH;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
   localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

   // Slot at a given offset from the head, wrapping at the ring depth.
   function automatic logic [SLOT_W-1:0] ring_slot(input logic [SLOT_W-1:0] head,
                                                   input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return SLOT_W'(sum);
   endfunction

   // Per-level ring pointers.
   logic [SLOT_W-1:0] head_ff [LEVELS];
   logic [CNT_W-1:0]  cnt_ff  [LEVELS];

   // Request being worked on.
   logic             act_ff;
   logic [ID_W-1:0]  id_ff;
   logic [LVL_W-1:0] lvl_ff, lvl_in;

   // Duplicate scan state.
   logic [CNT_W-1:0] off_ff;
   logic             pend_ff;
   logic             hit_ff;

   // Finished result and the output register.
   logic [ID_W-1:0]     res_id_ff;
   logic [LVL_W-1:0]    res_lvl_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic                out_valid_ff;
   logic [ID_W-1:0]     out_id_ff;
   logic [LEVEL_W-1:0]  out_level_ff;
   logic [STATUS_W-1:0] out_status_ff;

   logic [SLOT_W-1:0] cur_head;
   logic [CNT_W-1:0]  cur_cnt;
   logic              scan_more;
   logic [LVL_W-1:0]  pick_lvl;
   logic              any_ready;
   logic              rd_en;
   logic              wr_en;
   logic [SLOT_W-1:0] rd_slot;
   logic [SLOT_W-1:0] wr_slot;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ID_W-1:0]   rd_data;
   logic              hit_now;
   logic              is_full;

   assign cur_head  = head_ff[lvl_ff];
   assign cur_cnt   = cnt_ff[lvl_ff];
   assign scan_more = off_ff < cur_cnt;
   assign hit_now   = pend_ff && (rd_data == id_ff);
   assign is_full   = cur_cnt == DEPTH_C;

   // First non-empty level, level 0 having the highest priority.
   always_comb begin
      pick_lvl  = '0;
      any_ready = 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (cnt_ff[i] != '0) begin
            pick_lvl  = LVL_W'(i);
            any_ready = 1'b1;
         end
      end
   end

   // Clamp the requested level to the lowest priority level.
   always_comb begin
      if ({1'b0, in_level} >= (LEVEL_W + 1)'(LEVELS)) begin
         lvl_in = LAST_LVL;
      end else begin
         lvl_in = LVL_W'(in_level);
      end
   end

   // Store addressing: the scan and the dequeue share the read port.
   assign rd_en   = (cmd.scan && scan_more) || cmd.deq_read;
   assign rd_slot = cmd.deq_read ? cur_head : ring_slot(cur_head, off_ff);
   assign wr_slot = ring_slot(cur_head, cur_cnt);
   assign wr_en   = cmd.enq_finish && !hit_ff && !is_full;
   assign rd_addr = ADDR_W'(lvl_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rd_slot);
   assign wr_addr = ADDR_W'(lvl_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_slot);

   mlrq_ram #(
      .WIDTH (ID_W),
      .DEPTH (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (id_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ring pointers: an enqueue grows the level, a dequeue advances its head.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (wr_en) begin
         cnt_ff[lvl_ff] <= cur_cnt + CNT_W'(1);
      end else if (cmd.deq_finish) begin
         head_ff[lvl_ff] <= ring_slot(cur_head, CNT_W'(1));
         cnt_ff[lvl_ff]  <= cur_cnt - CNT_W'(1);
      end
   end

   // Request capture and the duplicate scan, one slot issued per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.accept) begin
         pend_ff <= 1'b0;
      end else if (cmd.scan) begin
         pend_ff <= scan_more;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= in_action;
         id_ff  <= in_task_id;
         lvl_ff <= lvl_in;
         off_ff <= '0;
         hit_ff <= 1'b0;
      end else if (cmd.pick) begin
         lvl_ff <= pick_lvl;
      end else if (cmd.scan) begin
         if (scan_more) begin
            off_ff <= off_ff + CNT_W'(1);
         end
         hit_ff <= hit_ff || hit_now;
      end
   end

   // Result of the finished request.
   always_ff @(posedge clock) begin
      if (cmd.enq_finish) begin
         res_id_ff  <= '0;
         res_lvl_ff <= lvl_ff;
         if (hit_ff) begin
            res_status_ff <= ST_DUPLICATE;
         end else if (is_full) begin
            res_status_ff <= ST_FULL;
         end else begin
            res_status_ff <= ST_ENQUEUED;
         end
      end else if (cmd.deq_finish) begin
         res_id_ff     <= rd_data;
         res_lvl_ff    <= lvl_ff;
         res_status_ff <= ST_DEQUEUED;
      end else if (cmd.empty_finish) begin
         res_id_ff     <= '0;
         res_lvl_ff    <= '0;
         res_status_ff <= ST_EMPTY;
      end
   end

   // Output register towards the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_id_ff     <= res_id_ff;
         out_level_ff  <= LEVEL_W'(res_lvl_ff);
         out_status_ff <= res_status_ff;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_task_id = out_id_ff;
   assign out_level   = out_level_ff;
   assign out_status  = out_status_ff;

   assign stat.is_deq    = act_ff == ACT_DEQUEUE;
   assign stat.any_ready = any_ready;
   assign stat.scan_done = !scan_more && !pend_ff;
   assign stat.out_free  = !out_valid_ff || out_ready;
endmodule

// ----- bench/multilevel_ready_queue_unit_tb.sv -----
`timescale 1ns / 1ps
module multilevel_ready_queue_unit_tb;
   import mlrq_pkg::*;

   localparam int LEVELS         = LEVELS_DEFAULT;
   localparam int DEPTH          = QUEUE_DEPTH_DEFAULT;
   localparam int REQUEST_TARGET = 1950;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 5000;
   localparam int DRAIN_CYCLES   = 40;

   // One response as the scheduler should produce it.
   typedef struct {
      logic [ID_W-1:0]     task_id;
      logic [LEVEL_W-1:0]  level;
      logic [STATUS_W-1:0] status;
   } sched_outcome_type;

   logic clock;
   logic reset;

   mlrq_req_if req_bus ();
   mlrq_rsp_if rsp_bus ();

   multilevel_ready_queue_unit #(
      .LEVELS      (LEVELS),
      .QUEUE_DEPTH (DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // Shadow copy of the rings, advanced as each request is accepted.
   logic [ID_W-1:0] ring_slots [LEVELS][DEPTH];
   int unsigned     ring_head  [LEVELS];
   int unsigned     ring_fill  [LEVELS];

   sched_outcome_type outcomes_due [$];

   int  error_count       = 0;
   int  sent_count        = 0;
   int  quiet_cycles      = 0;
   bit  src_idle          = 1'b1;
   bit  sink_idle         = 1'b1;
   bit  long_hold_pending = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Gap lengths: mostly short, now and then long.
   function automatic int idle_span();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   function automatic int unsigned ids_held();
      int unsigned total;
      int          i;
      total = 0;
      for (i = 0; i < LEVELS; i++)
         total += ring_fill[i];
      return total;
   endfunction

   // Applies one request to the shadow rings and returns the response it must give.
   function automatic sched_outcome_type schedule_request(input logic act,
                                                          input logic [ID_W-1:0] id,
                                                          input logic [LEVEL_W-1:0] lvl);
      sched_outcome_type res;
      int unsigned       lv;
      int                i;
      bit                seen;
      bit                found;
      res.task_id = '0;
      res.level   = '0;
      res.status  = ST_EMPTY;
      if (act == ACT_ENQUEUE) begin
         // Levels past the last one fall to the lowest priority.
         lv = (lvl >= LEVELS) ? LEVELS - 1 : lvl;
         res.level = LEVEL_W'(lv);
         seen = 1'b0;
         for (i = 0; i < ring_fill[lv]; i++)
            if (ring_slots[lv][(ring_head[lv] + i) % DEPTH] == id)
               seen = 1'b1;
         // The duplicate check takes precedence over the full check.
         if (seen) begin
            res.status = ST_DUPLICATE;
         end else if (ring_fill[lv] >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            ring_slots[lv][(ring_head[lv] + ring_fill[lv]) % DEPTH] = id;
            ring_fill[lv]++;
            res.status = ST_ENQUEUED;
         end
      end else begin
         found = 1'b0;
         for (i = 0; i < LEVELS; i++) begin
            if (!found && ring_fill[i] != 0) begin
               found       = 1'b1;
               res.task_id = ring_slots[i][ring_head[i]];
               res.level   = LEVEL_W'(i);
               res.status  = ST_DEQUEUED;
               ring_head[i] = (ring_head[i] + 1) % DEPTH;
               ring_fill[i]--;
            end
         end
      end
      return res;
   endfunction

   // Offers one request after an optional gap and waits until it is taken.
   task automatic send_request(input logic act, input logic [ID_W-1:0] id,
                               input logic [LEVEL_W-1:0] lvl);
      int gap;
      gap = src_idle ? idle_span() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.task_id <= id;
      req_bus.level   <= lvl;
      do @(posedge clock); while (!req_bus.ready);
      outcomes_due.push_back(schedule_request(act, id, lvl));
      sent_count++;
   endtask

   task automatic send_dequeue();
      send_request(ACT_DEQUEUE, ID_W'($urandom), LEVEL_W'($urandom));
   endtask

   // Empty dequeue, extreme ids, clamping, duplicates and priority order.
   task automatic test_empty_and_clamp();
      send_request(ACT_DEQUEUE, 8'hFF, 4'hF);
      send_request(ACT_ENQUEUE, 8'h00, 4'd0);
      send_request(ACT_ENQUEUE, 8'hFF, 4'd0);
      send_request(ACT_ENQUEUE, 8'h00, 4'd0);
      send_request(ACT_ENQUEUE, 8'hAA, 4'hF);
      send_request(ACT_ENQUEUE, 8'h55, 4'd4);
      send_request(ACT_ENQUEUE, 8'hAA, 4'd3);
      send_request(ACT_ENQUEUE, 8'hA5, 4'd2);
      send_request(ACT_ENQUEUE, 8'h5A, 4'd1);
      repeat (6) send_request(ACT_DEQUEUE, 8'h00, 4'hF);
      send_request(ACT_DEQUEUE, 8'h00, 4'd0);
   endtask

   // Fills a clamped level, then tries a new id and a repeated one, then drains it.
   task automatic test_full_ring();
      logic [ID_W-1:0] first_id;
      int              i;
      first_id = ID_W'($urandom_range(0, 15));
      send_request(ACT_ENQUEUE, first_id, 4'd9);
      for (i = 1; i < DEPTH; i++)
         send_request(ACT_ENQUEUE, ID_W'(i * 16 + $urandom_range(0, 15)), 4'd9);
      send_request(ACT_ENQUEUE, first_id ^ 8'h01, 4'd3);
      send_request(ACT_ENQUEUE, first_id, 4'd3);
      repeat (DEPTH + 1) send_dequeue();
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      src_idle          = 1'b0;
      long_hold_pending = 1'b1;
      repeat (12) begin
         if ($urandom_range(0, 1) == 0)
            send_request(ACT_ENQUEUE, ID_W'($urandom), LEVEL_W'($urandom));
         else
            send_dequeue();
      end
      src_idle = 1'b1;
   endtask

   // Bursts of fills, drains and mixed traffic with random content and idling.
   task automatic test_random_traffic();
      logic [LEVEL_W-1:0] lvl;
      int                 n;
      while (sent_count < REQUEST_TARGET) begin
         src_idle  = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1: begin
               lvl = LEVEL_W'($urandom);
               n   = $urandom_range(10, 20);
               repeat (n) begin
                  if ($urandom_range(0, 1) == 0)
                     send_request(ACT_ENQUEUE, ID_W'($urandom), lvl);
                  else
                     send_request(ACT_ENQUEUE, ID_W'($urandom_range(0, 31)), lvl);
               end
            end
            2, 3: begin
               n = ids_held() + $urandom_range(0, 2);
               repeat (n) send_dequeue();
            end
            default: begin
               n = $urandom_range(8, 24);
               repeat (n) begin
                  if ($urandom_range(0, 99) < 55) begin
                     if ($urandom_range(0, 1) == 0)
                        send_request(ACT_ENQUEUE, ID_W'($urandom_range(0, 7)),
                                     LEVEL_W'($urandom));
                     else
                        send_request(ACT_ENQUEUE, ID_W'($urandom), LEVEL_W'($urandom));
                  end else begin
                     send_dequeue();
                  end
               end
            end
         endcase
      end
      src_idle  = 1'b1;
      sink_idle = 1'b1;
   endtask

   // Receiver: random stalls, and one long hold when asked for.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (sink_idle && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (idle_span()) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Each accepted response is checked against the oldest outstanding one.
   always @(posedge clock) begin
      sched_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outcomes_due.size() == 0) begin
            $display("%0t: response with none outstanding: id %0d level %0d status %0d",
                     $time, rsp_bus.out_task_id, rsp_bus.out_level, rsp_bus.status);
            error_count++;
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_bus.out_task_id !== want.task_id) begin
               $display("%0t: out_task_id expected %0d actual %0d",
                        $time, want.task_id, rsp_bus.out_task_id);
               error_count++;
            end
            if (rsp_bus.out_level !== want.level) begin
               $display("%0t: out_level expected %0d actual %0d",
                        $time, want.level, rsp_bus.out_level);
               error_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_bus.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request or a response.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int i;
      for (i = 0; i < LEVELS; i++) begin
         ring_head[i] = 0;
         ring_fill[i] = 0;
      end
      req_bus.valid   = 1'b0;
      req_bus.action  = ACT_ENQUEUE;
      req_bus.task_id = '0;
      req_bus.level   = '0;
      reset           = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_clamp();
      test_full_ring();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mlrq_pkg.sv
hdl/mlrq_req_if.sv
hdl/mlrq_rsp_if.sv
hdl/mlrq_ram.sv
hdl/mlrq_ctrl.sv
hdl/mlrq_datapath.sv
hdl/multilevel_ready_queue_unit.sv
bench/multilevel_ready_queue_unit_tb.sv
